FILE: design/hpfb_pkg.sv
// Package: shared constants and types for the histogram peak bounds core.
`default_nettype none
package hpfb_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int BIN_AW     = $clog2(MAX_BINS);
    localparam int BIN_CW     = BIN_AW + 1;
    localparam int IDX_W      = 11;
    localparam int COUNT_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int THR_W      = COUNT_W + FRAC_W;
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;
    localparam int OUT_DW     = 72;

    localparam logic [FRAC_W-1:0] FRAC_RESET    = 16'd26214;
    localparam logic [APB_AW-1:0] REG_FRAC_ADDR = 2'd0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MULT,
        ST_UP,
        ST_DOWN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  empty_histogram;
        logic                  upper_found;
        logic                  lower_found;
        logic [IDX_W-1:0]      upper_bin;
        logic [IDX_W-1:0]      lower_bin;
        logic [COUNT_W-1:0]    peak_count;
        logic [IDX_W-1:0]      peak_bin;
    } res_t;

endpackage
`default_nettype wire

FILE: design/histogram_peak_fraction_bounds_core.sv
// Peak bin and threshold-crossing bounds of a streamed histogram.
// Load: one bin per cycle (s_tready high); the first 1024 go to the bin memory at once.
// After the last bin: a multiply step, then an upward and a downward scan (one read per
// cycle through the registered read port), then the output register; an all-zero
// histogram goes straight from loading to the done state and the output register.
// s_tready is low from the last bin until the result is registered. Reset: control only.
`default_nettype none
module histogram_peak_fraction_bounds_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hpfb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hpfb_pkg::APB_DW-1:0]   pwdata,
    output logic      [hpfb_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    // bin stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hpfb_pkg::COUNT_W-1:0]  s_tdata,   // [31:0] bin_count
    input  wire logic                          s_tlast,   // last_bin
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [10:0] peak_bin, [42:11] peak_count, [53:43] lower_bin, [64:54] upper_bin,
    // [65] lower_found, [66] upper_found, [71:67] zero
    output logic      [hpfb_pkg::OUT_DW-1:0]   m_tdata,
    output logic                               m_tuser    // empty_histogram
);

    hpfb_pkg::state_t                    state_reg, state_next;
    logic [hpfb_pkg::FRAC_W-1:0]         frac_reg;
    logic [hpfb_pkg::BIN_CW-1:0]         loaded_reg, loaded_next;
    logic [hpfb_pkg::COUNT_W-1:0]        max_reg, max_next, max_upd;
    logic [hpfb_pkg::BIN_AW-1:0]         idx_reg, idx_next, idx_upd;
    logic [hpfb_pkg::THR_W-1:0]          thr_reg;
    logic [hpfb_pkg::BIN_CW-1:0]         ptr_reg, ptr_next;
    logic                                rd_vld_reg, rd_vld_next;
    logic [hpfb_pkg::BIN_AW-1:0]         rd_addr_reg;
    logic [hpfb_pkg::COUNT_W-1:0]        rd_data_reg;
    hpfb_pkg::res_t                      scan_reg, scan_next;
    hpfb_pkg::res_t                      out_reg;
    logic                                out_vld_reg;

    logic [hpfb_pkg::COUNT_W-1:0]        bin_mem [hpfb_pkg::MAX_BINS];

    logic s_xfer, cfg_wr, store_en, hit, up_range, down_range, issue, out_load;

    assign pready   = 1'b1;
    assign prdata   = {{(hpfb_pkg::APB_DW-hpfb_pkg::FRAC_W){1'b0}}, frac_reg};
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == hpfb_pkg::REG_FRAC_ADDR);

    assign s_tready = (state_reg == hpfb_pkg::ST_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign store_en = s_xfer && (loaded_reg < hpfb_pkg::BIN_CW'(hpfb_pkg::MAX_BINS));

    assign max_upd  = (store_en && (s_tdata > max_reg)) ? s_tdata : max_reg;
    assign idx_upd  = (store_en && (s_tdata > max_reg)) ?
                      loaded_reg[hpfb_pkg::BIN_AW-1:0] : idx_reg;

    assign hit        = rd_vld_reg && ({rd_data_reg, {hpfb_pkg::FRAC_W{1'b0}}} < thr_reg);
    assign up_range   = ptr_reg < loaded_reg;
    assign down_range = ptr_reg <= {1'b0, idx_reg};
    assign issue      = !hit && (((state_reg == hpfb_pkg::ST_UP) && up_range) ||
                                 ((state_reg == hpfb_pkg::ST_DOWN) && down_range));
    assign out_load   = (state_reg == hpfb_pkg::ST_DONE) && (!out_vld_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpfb_pkg::ST_LOAD:
            begin
                if (s_xfer && s_tlast)
                    state_next = (max_upd == '0) ? hpfb_pkg::ST_DONE : hpfb_pkg::ST_MULT;
            end
            hpfb_pkg::ST_MULT:
                state_next = hpfb_pkg::ST_UP;
            hpfb_pkg::ST_UP:
            begin
                if (hit || (!up_range && !rd_vld_reg))
                    state_next = hpfb_pkg::ST_DOWN;
            end
            hpfb_pkg::ST_DOWN:
            begin
                if (hit || (!down_range && !rd_vld_reg))
                    state_next = hpfb_pkg::ST_DONE;
            end
            hpfb_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = hpfb_pkg::ST_LOAD;
            end
            default:
                state_next = hpfb_pkg::ST_LOAD;
        endcase
    end

    // datapath next values
    always_comb
    begin
        loaded_next = loaded_reg;
        max_next    = max_upd;
        idx_next    = idx_upd;
        ptr_next    = ptr_reg;
        rd_vld_next = issue;
        scan_next   = scan_reg;
        if (store_en)
            loaded_next = loaded_reg + 1'b1;
        case (state_reg)
            hpfb_pkg::ST_LOAD:
            begin
                if (s_xfer && s_tlast)
                begin
                    scan_next = '0;
                    // all-zero histogram: every other field stays zero
                    if (max_upd == '0)
                        scan_next.empty_histogram = 1'b1;
                    else
                    begin
                        scan_next.peak_count = max_upd;
                        scan_next.peak_bin   = hpfb_pkg::IDX_W'({1'b0, idx_upd} + 1'b1);
                    end
                end
            end
            hpfb_pkg::ST_MULT:
            begin
                ptr_next    = {1'b0, idx_reg};
                rd_vld_next = 1'b0;
            end
            hpfb_pkg::ST_UP:
            begin
                if (hit)
                begin
                    scan_next.upper_bin   = hpfb_pkg::IDX_W'({1'b0, rd_addr_reg} + 1'b1);
                    scan_next.upper_found = 1'b1;
                end
                if (state_next == hpfb_pkg::ST_DOWN)
                begin
                    ptr_next    = {1'b0, idx_reg};
                    rd_vld_next = 1'b0;
                end
                else if (issue)
                    ptr_next = ptr_reg + 1'b1;
            end
            hpfb_pkg::ST_DOWN:
            begin
                if (hit)
                begin
                    scan_next.lower_bin   = hpfb_pkg::IDX_W'({1'b0, rd_addr_reg} + 1'b1);
                    scan_next.lower_found = 1'b1;
                end
                if (issue)
                    ptr_next = ptr_reg - 1'b1;
            end
            hpfb_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    loaded_next = '0;
                    max_next    = '0;
                    idx_next    = '0;
                end
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
            bin_mem[loaded_reg[hpfb_pkg::BIN_AW-1:0]] <= s_tdata;
        rd_data_reg <= bin_mem[ptr_reg[hpfb_pkg::BIN_AW-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= ptr_reg[hpfb_pkg::BIN_AW-1:0];
        scan_reg    <= scan_next;
        if (state_reg == hpfb_pkg::ST_MULT)
            thr_reg <= max_reg * frac_reg;
        if (out_load)
            out_reg <= scan_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hpfb_pkg::ST_LOAD;
            frac_reg    <= hpfb_pkg::FRAC_RESET;
            loaded_reg  <= '0;
            max_reg     <= '0;
            idx_reg     <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            max_reg    <= max_next;
            idx_reg    <= idx_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
            if (cfg_wr)
                frac_reg <= pwdata[hpfb_pkg::FRAC_W-1:0];
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.empty_histogram;
    assign m_tdata  = {{(hpfb_pkg::OUT_DW - 3*hpfb_pkg::IDX_W - hpfb_pkg::COUNT_W - 2){1'b0}},
                       out_reg.upper_found, out_reg.lower_found,
                       out_reg.upper_bin, out_reg.lower_bin,
                       out_reg.peak_count, out_reg.peak_bin};

    // a new result only leaves the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == hpfb_pkg::ST_DONE))
        else $error("result loaded outside done state");

    // the peak always lies among the stored bins
    a_peak_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (max_reg != '0) |-> ({1'b0, idx_reg} < loaded_reg))
        else $error("peak index beyond stored bins");

    // reads in flight never reach past the stored bins
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> ({1'b0, rd_addr_reg} < loaded_reg))
        else $error("scan read beyond stored bins");

    // bounds sit on the proper side of the peak
    a_bound_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((!out_reg.upper_found || (out_reg.upper_bin >= out_reg.peak_bin)) &&
                      (!out_reg.lower_found || (out_reg.lower_bin <= out_reg.peak_bin))))
        else $error("bound on wrong side of peak");

    // input is held off for the whole scan
    a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hpfb_pkg::ST_UP) || (state_reg == hpfb_pkg::ST_DOWN)) |-> !store_en)
        else $error("bin stored during scan");

endmodule
`default_nettype wire
